FILE: rtl/b2bcd_pkg.sv
// Package for the binary to packed BCD converter.
// Holds the width constants, the pipeline stage record and the shift-add-3 step.
// No dependencies.
`default_nettype none

package b2bcd_pkg;

   localparam int VALUE_WIDTH      = 32;
   localparam int DIGIT_COUNT      = 8;
   localparam int BCD_WIDTH        = 4 * DIGIT_COUNT;
   localparam int OUT_WIDTH        = 32;
   localparam int STAGE_COUNT      = 8;
   localparam int SHIFTS_PER_STAGE = VALUE_WIDTH / STAGE_COUNT;

   function automatic longint unsigned pow10(input int n);
      longint unsigned acc;
      acc = 64'd1;
      for (int i = 0; i < n; i++) begin
         acc = acc * 64'd10;
      end
      return acc;
   endfunction

   localparam longint unsigned MAX_VALUE = pow10(DIGIT_COUNT) - 64'd1;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] bin;
      logic [BCD_WIDTH-1:0]   bcd;
      logic                   ovf;
   } stage_type;

   // one double dabble iteration: correct each digit, then shift one bit in
   function automatic stage_type dabble_step(input stage_type cur);
      stage_type nxt;
      logic [BCD_WIDTH-1:0] adj;
      nxt = cur;
      adj = cur.bcd;
      for (int d = 0; d < DIGIT_COUNT; d++) begin
         if (adj[4*d +: 4] >= 4'd5) begin
            adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
         end
      end
      nxt.bcd = {adj[BCD_WIDTH-2:0], cur.bin[VALUE_WIDTH-1]};
      nxt.bin = {cur.bin[VALUE_WIDTH-2:0], 1'b0};
      return nxt;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/binary_to_bcd_8digit.sv
// Binary to packed BCD converter, pipelined double dabble.
// Depends on b2bcd_pkg (widths, stage record, dabble step).
//
//   port group   dir   handshake              payload
//   req_         in    req_valid / req_stall  req_value[31:0]
//   rsp_         out   rsp_valid / rsp_stall  rsp_bcd_digits[31:0], rsp_overflow
//
// One transaction per cycle when rsp_stall does not hold the pipeline. Stages: one input
// register with the range check, then eight stages of four shift-add-3 steps.
// Reset clears only the per-stage valid bits.
// Each stage holds while its successor is full and stalled; empty stages keep
// filling, so input is taken while a result waits on rsp_stall.
`default_nettype none

module binary_to_bcd_8digit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [b2bcd_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [b2bcd_pkg::OUT_WIDTH-1:0]      rsp_bcd_digits,
   output logic                                 rsp_overflow
);
   import b2bcd_pkg::*;

   logic      valid_ff [0:STAGE_COUNT];
   stage_type data_ff  [0:STAGE_COUNT];
   stage_type data_in  [0:STAGE_COUNT];
   logic      stage_ready [0:STAGE_COUNT];

   always_comb begin
      stage_ready[STAGE_COUNT] = !valid_ff[STAGE_COUNT] || !rsp_stall;
      for (int i = STAGE_COUNT - 1; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
   end

   always_comb begin
      data_in[0].bin = req_value;
      data_in[0].bcd = '0;
      data_in[0].ovf = (64'(req_value) > MAX_VALUE);
   end

   for (genvar s = 1; s <= STAGE_COUNT; s++) begin : g_stage
      always_comb begin
         stage_type cur;
         cur = data_ff[s-1];
         for (int k = 0; k < SHIFTS_PER_STAGE; k++) begin
            cur = dabble_step(cur);
         end
         data_in[s] = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= STAGE_COUNT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (stage_ready[0]) begin
            valid_ff[0] <= req_valid;
            if (req_valid) begin
               data_ff[0] <= data_in[0];
            end
         end
         for (int i = 1; i <= STAGE_COUNT; i++) begin
            if (stage_ready[i]) begin
               valid_ff[i] <= valid_ff[i-1];
               if (valid_ff[i-1]) begin
                  data_ff[i] <= data_in[i];
               end
            end
         end
      end
   end

   assign req_stall      = !stage_ready[0];
   assign rsp_valid      = valid_ff[STAGE_COUNT];
   assign rsp_overflow   = data_ff[STAGE_COUNT].ovf;
   assign rsp_bcd_digits = data_ff[STAGE_COUNT].ovf ? '1
                                                    : OUT_WIDTH'(data_ff[STAGE_COUNT].bcd);

endmodule

`default_nettype wire
